// ===== sv/pee_pkg.sv =====
package pee_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int SYM_WIDTH    = 8;
  localparam int OUT_WIDTH    = 32;
  localparam int STATUS_WIDTH = 2;

  localparam logic [SYM_WIDTH-1:0] SYM_PLUS = 8'h2B;
  localparam logic [SYM_WIDTH-1:0] SYM_STAR = 8'h2A;
  localparam logic [SYM_WIDTH-1:0] SYM_ZERO = 8'h30;
  localparam logic [SYM_WIDTH-1:0] SYM_NINE = 8'h39;
  localparam int DEC_BASE = 10;

  typedef logic [STATUS_WIDTH-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_OVER  = 2'd2;

  localparam int ERR_UNDER_BIT = 0;
  localparam int ERR_OVER_BIT  = 1;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    status_t                     status;
  } result_t;

endpackage

// ===== sv/pee_if.sv =====
interface pee_in_if;
  import pee_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SYM_WIDTH-1:0] symbol;
  logic                 end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface pee_out_if;
  import pee_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] value;
  status_t                     status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== sv/postfix_expression_evaluator.sv =====
// Channel  Dir  Beat payload          Handshake
// in_bus   in   symbol, end_of_expr   valid/ready
// out_bus  out  value, status         valid/ready
//
// One character per cycle while in_bus.ready is high: top and next-on-stack sit in registers,
// deeper entries in a one-port-read, one-port-write stack memory whose registered read is addressed ahead.
// A result is registered into a two-entry queue on its end-of-expression beat and leaves from there.
// in_bus.ready drops only while two results wait; out_bus stalls never touch the stack.
// Reset (rst_n low, synchronous) empties the stack and clears flags and queue.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = pee_pkg::DEF_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pee_in_if.sink    in_bus,
  pee_out_if.source out_bus
);
  import pee_pkg::*;

  localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;

  logic [LVL_W-1:0]       lvl_r, lvl_nxt, lvl_op;
  logic [VALUE_WIDTH-1:0] tos_r, tos_nxt;
  logic [VALUE_WIDTH-1:0] nos_r, nos_nxt;
  logic                   in_num_r, in_num_nxt;
  logic [1:0]             err_r, err_nxt, err_op;

  logic                   mem_we;
  logic [MEM_AW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic                   in_acc;
  logic                   is_digit;
  logic [VALUE_WIDTH-1:0] digit;
  logic [LVL_W-1:0]       lvl_m2, lvl_m3;

  result_t                res;
  logic [63:0]            res_ext;
  logic                   res_push;

  result_t                slot_r [2];
  logic                   wr_ptr_r, rd_ptr_r;
  logic [1:0]             cnt_r;
  logic                   out_pop;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign is_digit = (in_bus.symbol >= SYM_ZERO) && (in_bus.symbol <= SYM_NINE);
  assign digit    = VALUE_WIDTH'(in_bus.symbol - SYM_ZERO);
  assign lvl_m2   = lvl_r - LVL_W'(2);

  always_comb begin
    lvl_op     = lvl_r;
    tos_nxt    = tos_r;
    nos_nxt    = nos_r;
    in_num_nxt = in_num_r;
    err_op     = err_r;
    mem_we     = 1'b0;
    mem_waddr  = lvl_m2[MEM_AW-1:0];
    mem_wdata  = nos_r;
    if (in_acc) begin
      if (is_digit) begin
        priority if (in_num_r && (lvl_r != '0)) begin
          tos_nxt = VALUE_WIDTH'(tos_r * VALUE_WIDTH'(DEC_BASE) + digit);
        end else if (lvl_r >= LVL_W'(STACK_DEPTH)) begin
          err_op[ERR_OVER_BIT] = 1'b1;
          in_num_nxt           = 1'b0;
        end else begin
          mem_we     = (lvl_r >= LVL_W'(2));
          nos_nxt    = tos_r;
          tos_nxt    = digit;
          lvl_op     = lvl_r + LVL_W'(1);
          in_num_nxt = 1'b1;
        end
      end else begin
        in_num_nxt = 1'b0;
        if ((in_bus.symbol == SYM_PLUS) || (in_bus.symbol == SYM_STAR)) begin
          if (lvl_r < LVL_W'(2)) begin
            err_op[ERR_UNDER_BIT] = 1'b1;
          end else begin
            tos_nxt = (in_bus.symbol == SYM_STAR) ? VALUE_WIDTH'(tos_r * nos_r)
                                                  : VALUE_WIDTH'(tos_r + nos_r);
            nos_nxt = rd_q;
            lvl_op  = lvl_r - LVL_W'(1);
          end
        end
      end
    end
  end

  assign res_push = in_acc && in_bus.end_of_expr;

  always_comb begin
    res_ext    = (lvl_op != '0) ? 64'(tos_nxt) : 64'd0;
    res.value  = res_ext[OUT_WIDTH-1:0];
    err_nxt    = err_op;
    lvl_nxt    = lvl_op;
    if (res_push && (lvl_op == '0)) begin
      err_nxt[ERR_UNDER_BIT] = 1'b1;
    end
    priority if (err_nxt[ERR_UNDER_BIT]) res.status = ST_UNDER;
    else if (err_nxt[ERR_OVER_BIT])      res.status = ST_OVER;
    else                                 res.status = ST_OK;
    if (res_push) begin
      lvl_nxt = '0;
      err_nxt = '0;
    end
  end

  assign lvl_m3    = lvl_nxt - LVL_W'(3);
  assign mem_raddr = lvl_m3[MEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rd_q <= mem_wdata;
    end else begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r    <= '0;
      in_num_r <= 1'b0;
      err_r    <= '0;
    end else begin
      lvl_r    <= lvl_nxt;
      in_num_r <= res_push ? 1'b0 : in_num_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    nos_r <= nos_nxt;
  end

  assign out_pop = out_bus.valid && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (res_push) wr_ptr_r <= ~wr_ptr_r;
      if (out_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(res_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

  assign in_bus.ready   = (cnt_r != 2'd2);
  assign out_bus.valid  = (cnt_r != 2'd0);
  assign out_bus.value  = slot_r[rd_ptr_r].value;
  assign out_bus.status = slot_r[rd_ptr_r].status;

  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (lvl_r == '0) && (err_r == '0) && !in_num_r)
    else $error("expression state not cleared after end beat");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> out_bus.valid)
    else $error("end beat gave no result");

  a_num_on_stack: assert property (@(posedge clk) disable iff (!rst_n)
    in_num_r |-> (lvl_r != '0))
    else $error("number in progress on empty stack");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue overrun");

endmodule
